// ===== sv/mdfr_pkg.sv =====
package mdfr_pkg;

    localparam int FreqW   = 13;
    localparam int GainW   = 4;
    localparam int VoltW   = 17;
    localparam int SpeedW  = 22;
    localparam int TorqueW = 14;
    localparam int AddrW   = 4;
    localparam int DataW   = 32;

    localparam int SpeedFactor = 294;

    localparam logic [FreqW-1:0] RampStepRst  = FreqW'(100);
    localparam logic [FreqW-1:0] StartFreqRst = FreqW'(3000);
    localparam logic [FreqW-1:0] MaxFreqRst   = FreqW'(6000);
    localparam logic [GainW-1:0] VoltGainRst  = GainW'(8);

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_STARTING,
        MODE_RUNNING,
        MODE_STOPPING
    } t_mode;

    typedef enum logic [1:0] {
        FUNC_TICK,
        FUNC_START,
        FUNC_STOP,
        FUNC_SET_FREQ
    } t_func;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_IGNORED,
        STATUS_OVER_MAX
    } t_status;

    typedef enum logic [1:0] {
        REG_RAMP_STEP,
        REG_START_FREQ,
        REG_MAX_FREQ,
        REG_VOLT_GAIN
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]       func;
        logic [FreqW-1:0] setpoint;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         status;
        logic [FreqW-1:0]   out_frequency;
        logic [VoltW-1:0]   out_voltage;
        logic [SpeedW-1:0]  shaft_speed;
        logic [TorqueW-1:0] shaft_torque;
    } t_out_item;

    typedef struct packed {
        logic [FreqW-1:0] ramp_step;
        logic [FreqW-1:0] start_frequency;
        logic [FreqW-1:0] freq_limit;
        logic [GainW-1:0] volt_gain;
    } t_cfg;

    typedef struct packed {
        t_mode            mode;
        t_status          status;
        logic [FreqW-1:0] freq;
    } t_mid;

endpackage

// ===== sv/mdfr_cfg.sv =====
module mdfr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdfr_pkg::AddrW-1:0]  paddr,
    input  logic [mdfr_pkg::DataW-1:0]  pwdata,
    output logic [mdfr_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    output mdfr_pkg::t_cfg              o_cfg
);

    logic [mdfr_pkg::FreqW-1:0] r_ramp_step;
    logic [mdfr_pkg::FreqW-1:0] r_start_freq;
    logic [mdfr_pkg::FreqW-1:0] r_max_freq;
    logic [mdfr_pkg::GainW-1:0] r_volt_gain;

    mdfr_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign reg_idx = mdfr_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step  <= mdfr_pkg::RampStepRst;
            r_start_freq <= mdfr_pkg::StartFreqRst;
            r_max_freq   <= mdfr_pkg::MaxFreqRst;
            r_volt_gain  <= mdfr_pkg::VoltGainRst;
        end else if (wr_en) begin
            unique case (reg_idx)
                mdfr_pkg::REG_RAMP_STEP:  r_ramp_step  <= pwdata[mdfr_pkg::FreqW-1:0];
                mdfr_pkg::REG_START_FREQ: r_start_freq <= pwdata[mdfr_pkg::FreqW-1:0];
                mdfr_pkg::REG_MAX_FREQ:   r_max_freq   <= pwdata[mdfr_pkg::FreqW-1:0];
                mdfr_pkg::REG_VOLT_GAIN:  r_volt_gain  <= pwdata[mdfr_pkg::GainW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mdfr_pkg::REG_RAMP_STEP:  prdata = mdfr_pkg::DataW'(r_ramp_step);
            mdfr_pkg::REG_START_FREQ: prdata = mdfr_pkg::DataW'(r_start_freq);
            mdfr_pkg::REG_MAX_FREQ:   prdata = mdfr_pkg::DataW'(r_max_freq);
            mdfr_pkg::REG_VOLT_GAIN:  prdata = mdfr_pkg::DataW'(r_volt_gain);
        endcase
    end

    assign o_cfg.ramp_step       = r_ramp_step;
    assign o_cfg.start_frequency = r_start_freq;
    assign o_cfg.freq_limit      = r_max_freq;
    assign o_cfg.volt_gain       = r_volt_gain;

endmodule

// ===== sv/mdfr_ctrl.sv =====
module mdfr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mdfr_pkg::t_in_item  i_item,
    input  mdfr_pkg::t_cfg      i_cfg,
    input  logic                i_ready,
    output logic                o_ready,
    output logic                o_valid,
    output mdfr_pkg::t_mid      o_mid
);

    localparam int FW = mdfr_pkg::FreqW;

    mdfr_pkg::t_mode   r_mode, n_mode;
    mdfr_pkg::t_status r_status, n_status;
    logic [FW-1:0]     r_tgt, n_tgt;
    logic [FW-1:0]     r_cur, n_cur;
    logic              r_valid, n_valid;

    logic          fire;
    logic          tgt_above;
    logic [FW-1:0] diff;
    logic [FW-1:0] stepped;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    assign tgt_above = r_tgt > r_cur;
    assign diff      = tgt_above ? (r_tgt - r_cur) : (r_cur - r_tgt);
    assign stepped   = tgt_above ? (r_cur + i_cfg.ramp_step) : (r_cur - i_cfg.ramp_step);

    always_comb begin
        n_mode   = r_mode;
        n_tgt    = r_tgt;
        n_cur    = r_cur;
        n_status = mdfr_pkg::STATUS_DONE;
        unique case (mdfr_pkg::t_func'(i_item.func))
            mdfr_pkg::FUNC_TICK: begin
                unique case (r_mode)
                    mdfr_pkg::MODE_STARTING: begin
                        if (diff < i_cfg.ramp_step) begin
                            n_cur  = r_tgt;
                            n_mode = mdfr_pkg::MODE_RUNNING;
                        end else begin
                            n_cur = stepped;
                        end
                    end
                    mdfr_pkg::MODE_RUNNING: begin
                        n_cur = (diff > i_cfg.ramp_step) ? stepped : r_tgt;
                    end
                    mdfr_pkg::MODE_STOPPING: begin
                        if (r_cur < i_cfg.ramp_step) begin
                            n_cur  = '0;
                            n_mode = mdfr_pkg::MODE_OFF;
                        end else begin
                            n_cur = r_cur - i_cfg.ramp_step;
                        end
                    end
                    mdfr_pkg::MODE_OFF: begin
                        n_cur = '0;
                    end
                endcase
            end
            mdfr_pkg::FUNC_START: begin
                if (r_mode == mdfr_pkg::MODE_OFF) begin
                    n_mode = mdfr_pkg::MODE_STARTING;
                    n_tgt  = i_cfg.start_frequency;
                end else begin
                    n_status = mdfr_pkg::STATUS_IGNORED;
                end
            end
            mdfr_pkg::FUNC_STOP: begin
                if (r_mode == mdfr_pkg::MODE_RUNNING || r_mode == mdfr_pkg::MODE_STARTING) begin
                    n_mode = mdfr_pkg::MODE_STOPPING;
                    n_tgt  = '0;
                end else begin
                    n_status = mdfr_pkg::STATUS_IGNORED;
                end
            end
            mdfr_pkg::FUNC_SET_FREQ: begin
                priority if (i_item.setpoint > i_cfg.freq_limit) begin
                    n_status = mdfr_pkg::STATUS_OVER_MAX;
                end else if (r_mode != mdfr_pkg::MODE_RUNNING) begin
                    n_status = mdfr_pkg::STATUS_IGNORED;
                end else begin
                    n_tgt = i_item.setpoint;
                end
            end
        endcase
    end

    always_comb begin
        if (fire) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= mdfr_pkg::MODE_OFF;
            r_tgt   <= '0;
            r_cur   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (fire) begin
                r_mode <= n_mode;
                r_tgt  <= n_tgt;
                r_cur  <= n_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
        end
    end

    // state registers hold the result of the item in this stage
    assign o_valid      = r_valid;
    assign o_mid.mode   = r_mode;
    assign o_mid.status = r_status;
    assign o_mid.freq   = r_cur;

endmodule

// ===== sv/mdfr_scale.sv =====
module mdfr_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  mdfr_pkg::t_mid             i_mid,
    input  logic [mdfr_pkg::GainW-1:0] i_volt_gain,
    input  logic                       i_stall,
    output logic                       o_ready,
    output logic                       o_valid,
    output mdfr_pkg::t_out_item        o_item
);

    localparam int VW = mdfr_pkg::VoltW;
    localparam int SW = mdfr_pkg::SpeedW;
    localparam int TW = mdfr_pkg::TorqueW;

    logic                r_valid, n_valid;
    mdfr_pkg::t_out_item r_item, n_item;
    logic                fire;

    assign o_ready = !r_valid || !i_stall;
    assign fire    = i_valid && o_ready;

    always_comb begin
        n_item.mode          = i_mid.mode;
        n_item.status        = i_mid.status;
        n_item.out_frequency = i_mid.freq;
        n_item.out_voltage   = VW'(i_mid.freq) * VW'(i_volt_gain);
        n_item.shaft_speed   = SW'(i_mid.freq) * SW'(mdfr_pkg::SpeedFactor);
        n_item.shaft_torque  = TW'({i_mid.freq, 1'b0});
    end

    always_comb begin
        if (fire) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/motor_drive_frequency_ramp.sv =====
// Channel  Direction  Handshake                 Payload
// -------  ---------  ------------------------  ----------------------------
// input    in         i_in_valid / o_in_stall   i_in_item  (t_in_item)
// output   out        o_out_valid / i_out_stall o_out_item (t_out_item)
// config   in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// Three register stages: input register, ramp/mode update, scaling to the
// output register. One transfer per cycle while no stall holds the pipeline;
// a result passes the input, ramp/mode and output registers in that order.
// Synchronous active-low reset clears valids and drive state, loads the
// register defaults. A stall on the output backs up stage by stage; the
// input takes a transfer whenever the input register is free or moving.
module motor_drive_frequency_ramp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mdfr_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mdfr_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdfr_pkg::AddrW-1:0]  paddr,
    input  logic [mdfr_pkg::DataW-1:0]  pwdata,
    output logic [mdfr_pkg::DataW-1:0]  prdata,
    output logic                        pready
);

    mdfr_pkg::t_cfg     cfg;
    mdfr_pkg::t_in_item r_in_item;
    logic               r_in_valid, n_in_valid;
    logic               in_ready;
    logic               in_fire;
    logic               ctrl_ready;
    logic               mid_valid;
    mdfr_pkg::t_mid     mid;
    logic               scale_ready;

    mdfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_ready   = !r_in_valid || ctrl_ready;
    assign in_fire    = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    always_comb begin
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (ctrl_ready) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= i_in_item;
        end
    end

    mdfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .i_ready (scale_ready),
        .o_ready (ctrl_ready),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    mdfr_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (mid_valid),
        .i_mid       (mid),
        .i_volt_gain (cfg.volt_gain),
        .i_stall     (i_out_stall),
        .o_ready     (scale_ready),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item)
    );

    a_off_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.mode == mdfr_pkg::MODE_OFF)
            |-> (o_out_item.out_frequency == '0))
        else $error("drive off with nonzero frequency");

    a_torque_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.shaft_torque == {o_out_item.out_frequency, 1'b0}))
        else $error("torque does not match frequency");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

endmodule

// ===== tb/tb_motor_drive_frequency_ramp.sv =====
module tb_motor_drive_frequency_ramp;

    localparam int PlanRows    = 27;
    localparam int Phases      = 8;
    localparam int PhaseItems  = 180;
    localparam int SettleTicks = 6;
    localparam int FreqW       = mdfr_pkg::FreqW;
    localparam int GainW       = mdfr_pkg::GainW;
    localparam int AddrW       = mdfr_pkg::AddrW;
    localparam int DataW       = mdfr_pkg::DataW;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    mdfr_pkg::t_in_item   i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    mdfr_pkg::t_out_item  o_out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrW-1:0]     paddr;
    logic [DataW-1:0]     pwdata;
    logic [DataW-1:0]     prdata;
    logic                 pready;

    typedef struct packed {
        mdfr_pkg::t_in_item  item;
        bit                  fixed;
        mdfr_pkg::t_out_item want;
    } t_stim;

    typedef struct {
        mdfr_pkg::t_func   func;
        logic [FreqW-1:0]  sp;
        bit                fixed;
        mdfr_pkg::t_mode   mode;
        mdfr_pkg::t_status st;
    } t_row;

    t_stim               stim_q[$];
    mdfr_pkg::t_out_item readings_q[$];
    mdfr_pkg::t_out_item pending_head;
    int                  fail_cnt = 0;

    // drive shadow
    mdfr_pkg::t_cfg   cfg = '{mdfr_pkg::RampStepRst, mdfr_pkg::StartFreqRst,
                              mdfr_pkg::MaxFreqRst, mdfr_pkg::VoltGainRst};
    mdfr_pkg::t_mode  drv_mode = mdfr_pkg::MODE_OFF;
    logic [FreqW-1:0] drv_target = '0;
    logic [FreqW-1:0] drv_freq = '0;

    motor_drive_frequency_ramp u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_motor_drive_frequency_ramp NOT OK");
        $finish;
    end

    task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    function automatic logic [FreqW-1:0] ramp_toward(logic [FreqW-1:0] cur,
                                                     logic [FreqW-1:0] tgt,
                                                     logic [FreqW-1:0] step);
        return (tgt > cur) ? cur + step : cur - step;
    endfunction

    function automatic mdfr_pkg::t_out_item next_reading(mdfr_pkg::t_in_item it);
        logic [FreqW-1:0]    d;
        mdfr_pkg::t_status   st;
        mdfr_pkg::t_out_item r;
        st = mdfr_pkg::STATUS_DONE;
        d = (drv_target > drv_freq) ? drv_target - drv_freq : drv_freq - drv_target;
        case (mdfr_pkg::t_func'(it.func))
            mdfr_pkg::FUNC_TICK: begin
                case (drv_mode)
                    mdfr_pkg::MODE_STARTING: begin
                        if (d < cfg.ramp_step) begin
                            drv_freq = drv_target;
                            drv_mode = mdfr_pkg::MODE_RUNNING;
                        end else begin
                            drv_freq = ramp_toward(drv_freq, drv_target, cfg.ramp_step);
                        end
                    end
                    mdfr_pkg::MODE_RUNNING: begin
                        if (d > cfg.ramp_step)
                            drv_freq = ramp_toward(drv_freq, drv_target, cfg.ramp_step);
                        else
                            drv_freq = drv_target;
                    end
                    mdfr_pkg::MODE_STOPPING: begin
                        if (drv_freq < cfg.ramp_step) begin
                            drv_freq = '0;
                            drv_mode = mdfr_pkg::MODE_OFF;
                        end else begin
                            drv_freq = drv_freq - cfg.ramp_step;
                        end
                    end
                    default: drv_freq = '0;
                endcase
            end
            mdfr_pkg::FUNC_START: begin
                if (drv_mode == mdfr_pkg::MODE_OFF) begin
                    drv_mode = mdfr_pkg::MODE_STARTING;
                    drv_target = cfg.start_frequency;
                end else begin
                    st = mdfr_pkg::STATUS_IGNORED;
                end
            end
            mdfr_pkg::FUNC_STOP: begin
                if (drv_mode == mdfr_pkg::MODE_RUNNING ||
                    drv_mode == mdfr_pkg::MODE_STARTING) begin
                    drv_mode = mdfr_pkg::MODE_STOPPING;
                    drv_target = '0;
                end else begin
                    st = mdfr_pkg::STATUS_IGNORED;
                end
            end
            default: begin
                if (it.setpoint > cfg.freq_limit)
                    st = mdfr_pkg::STATUS_OVER_MAX;
                else if (drv_mode != mdfr_pkg::MODE_RUNNING)
                    st = mdfr_pkg::STATUS_IGNORED;
                else
                    drv_target = it.setpoint;
            end
        endcase
        r.mode          = drv_mode;
        r.status        = st;
        r.out_frequency = drv_freq;
        r.out_voltage   = mdfr_pkg::VoltW'(int'(drv_freq) * int'(cfg.volt_gain));
        r.shaft_speed   = mdfr_pkg::SpeedW'(int'(drv_freq) * mdfr_pkg::SpeedFactor);
        r.shaft_torque  = mdfr_pkg::TorqueW'({drv_freq, 1'b0});
        return r;
    endfunction

    function automatic logic [DataW-1:0] reg_shadow(mdfr_pkg::t_reg_idx idx);
        case (idx)
            mdfr_pkg::REG_RAMP_STEP:  return DataW'(cfg.ramp_step);
            mdfr_pkg::REG_START_FREQ: return DataW'(cfg.start_frequency);
            mdfr_pkg::REG_MAX_FREQ:   return DataW'(cfg.freq_limit);
            default:                  return DataW'(cfg.volt_gain);
        endcase
    endfunction

    // psel stays up between back-to-back transfers; reg_idle drops it
    task automatic reg_write(mdfr_pkg::t_reg_idx idx, logic [DataW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            mdfr_pkg::REG_RAMP_STEP:  cfg.ramp_step = val[FreqW-1:0];
            mdfr_pkg::REG_START_FREQ: cfg.start_frequency = val[FreqW-1:0];
            mdfr_pkg::REG_MAX_FREQ:   cfg.freq_limit = val[FreqW-1:0];
            default:                  cfg.volt_gain = val[GainW-1:0];
        endcase
    endtask

    task automatic reg_check(mdfr_pkg::t_reg_idx idx);
        logic [DataW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AddrW'(4 * int'(idx));
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got != reg_shadow(idx))
            flag_mismatch("register readback", reg_shadow(idx), got);
    endtask

    task automatic reg_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_cfg(mdfr_pkg::t_cfg c);
        reg_write(mdfr_pkg::REG_RAMP_STEP, DataW'(c.ramp_step));
        reg_write(mdfr_pkg::REG_START_FREQ, DataW'(c.start_frequency));
        reg_write(mdfr_pkg::REG_MAX_FREQ, DataW'(c.freq_limit));
        reg_write(mdfr_pkg::REG_VOLT_GAIN, DataW'(c.volt_gain));
        reg_check(mdfr_pkg::REG_RAMP_STEP);
        reg_check(mdfr_pkg::REG_START_FREQ);
        reg_check(mdfr_pkg::REG_MAX_FREQ);
        reg_check(mdfr_pkg::REG_VOLT_GAIN);
        reg_idle();
    endtask

    function automatic logic [FreqW-1:0] rand_sp();
        return FreqW'($urandom_range(0, 8191));
    endfunction

    task automatic push_item(mdfr_pkg::t_func f, logic [FreqW-1:0] sp);
        t_stim s;
        s = '0;
        s.item.func = f;
        s.item.setpoint = sp;
        stim_q.push_back(s);
    endtask

    // start, ramp up, a few setpoint changes, stop, ramp down
    task automatic plan_drive_run();
        int span;
        span = (cfg.ramp_step == 0) ? 6
             : int'(cfg.start_frequency) / int'(cfg.ramp_step) + 3;
        if (span > 40)
            span = 40;
        push_item(mdfr_pkg::FUNC_START, rand_sp());
        repeat ($urandom_range(span / 2, span)) push_item(mdfr_pkg::FUNC_TICK, rand_sp());
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 6) != 0)
                push_item(mdfr_pkg::FUNC_SET_FREQ,
                          FreqW'($urandom_range(0, cfg.freq_limit)));
            else
                push_item(mdfr_pkg::FUNC_SET_FREQ, rand_sp());
            repeat ($urandom_range(0, 12)) push_item(mdfr_pkg::FUNC_TICK, rand_sp());
        end
        push_item(mdfr_pkg::FUNC_STOP, rand_sp());
        repeat ($urandom_range(0, span + 5)) push_item(mdfr_pkg::FUNC_TICK, rand_sp());
    endtask

    task automatic run_stimulus();
        int                  burst;
        int                  gap;
        t_stim               s;
        mdfr_pkg::t_out_item r;
        while (stim_q.size() > 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            for (int k = 0; k < burst && stim_q.size() > 0; k++) begin
                s = stim_q.pop_front();
                i_in_valid <= 1'b1;
                i_in_item  <= s.item;
                do @(posedge i_clk); while (o_in_stall);
                r = next_reading(s.item);
                readings_q.push_back(s.fixed ? s.want : r);
            end
            if (gap > 0 && stim_q.size() > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (readings_q.size() > 0) @(posedge i_clk);
        repeat (SettleTicks) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (readings_q.size() == 0) begin
                flag_mismatch("transfer with nothing pending", 0, 1);
            end else begin
                pending_head = readings_q.pop_front();
                if (o_out_item.mode != pending_head.mode)
                    flag_mismatch("mode", pending_head.mode, o_out_item.mode);
                if (o_out_item.status != pending_head.status)
                    flag_mismatch("status", pending_head.status, o_out_item.status);
                if (o_out_item.out_frequency != pending_head.out_frequency)
                    flag_mismatch("out_frequency", pending_head.out_frequency,
                                  o_out_item.out_frequency);
                if (o_out_item.out_voltage != pending_head.out_voltage)
                    flag_mismatch("out_voltage", pending_head.out_voltage,
                                  o_out_item.out_voltage);
                if (o_out_item.shaft_speed != pending_head.shaft_speed)
                    flag_mismatch("shaft_speed", pending_head.shaft_speed,
                                  o_out_item.shaft_speed);
                if (o_out_item.shaft_torque != pending_head.shaft_torque)
                    flag_mismatch("shaft_torque", pending_head.shaft_torque,
                                  o_out_item.shaft_torque);
            end
        end
    end

    // receiver stall pattern, with a long hold-off every so often
    initial begin : out_side
        int seg;
        int len;
        int pct;
        seg = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            seg++;
            if (seg % 25 == 7) begin
                len = 120;
                pct = 100;
            end else begin
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 30;
                    2:       pct = 60;
                    default: pct = 90;
                endcase
                len = $urandom_range(4, 40);
            end
            repeat (len) begin
                i_out_stall <= ($urandom_range(0, 99) < pct);
                @(posedge i_clk);
            end
        end
    end

    initial begin : main
        t_row           plan [PlanRows];
        t_stim          s;
        mdfr_pkg::t_cfg phase_cfg [Phases];
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // typed rows all sit at zero frequency
        plan = '{
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b1,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_STOP,     13'd8191, 1'b1,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_IGNORED},
            '{mdfr_pkg::FUNC_SET_FREQ, 13'd8191, 1'b1,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_OVER_MAX},
            '{mdfr_pkg::FUNC_SET_FREQ, 13'd0,    1'b1,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_IGNORED},
            '{mdfr_pkg::FUNC_START,    13'd4095, 1'b1,
              mdfr_pkg::MODE_STARTING, mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_START,    13'd0,    1'b1,
              mdfr_pkg::MODE_STARTING, mdfr_pkg::STATUS_IGNORED},
            '{mdfr_pkg::FUNC_SET_FREQ, 13'd100,  1'b1,
              mdfr_pkg::MODE_STARTING, mdfr_pkg::STATUS_IGNORED},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd8191, 1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_SET_FREQ, 13'd6000, 1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_SET_FREQ, 13'd6001, 1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_SET_FREQ, 13'd5500, 1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_START,    13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_STOP,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_STOP,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_SET_FREQ, 13'd10,   1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE},
            '{mdfr_pkg::FUNC_TICK,     13'd0,    1'b0,
              mdfr_pkg::MODE_OFF,      mdfr_pkg::STATUS_DONE}
        };

        phase_cfg[0] = '{mdfr_pkg::RampStepRst, mdfr_pkg::StartFreqRst,
                         mdfr_pkg::MaxFreqRst, mdfr_pkg::VoltGainRst};
        phase_cfg[1] = '{13'd8191, 13'd8191, 13'd8191, 4'd15};
        phase_cfg[2] = '{13'd1, 13'd0, 13'd0, 4'd0};
        phase_cfg[3] = '{13'd0, 13'd500, 13'd4000, 4'd3};
        phase_cfg[4] = '{13'd1, 13'd10, 13'd30, 4'd15};
        for (int p = 5; p < Phases; p++) begin
            phase_cfg[p].start_frequency = FreqW'($urandom_range(0, 8191));
            phase_cfg[p].ramp_step = FreqW'($urandom_range(
                int'(phase_cfg[p].start_frequency) / 30 + 1, 8191));
            phase_cfg[p].freq_limit = FreqW'($urandom_range(0, 8191));
            phase_cfg[p].volt_gain = GainW'($urandom_range(0, 15));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reg_check(mdfr_pkg::REG_RAMP_STEP);
        reg_check(mdfr_pkg::REG_START_FREQ);
        reg_check(mdfr_pkg::REG_MAX_FREQ);
        reg_check(mdfr_pkg::REG_VOLT_GAIN);
        reg_write(mdfr_pkg::REG_RAMP_STEP, DataW'(1000));
        reg_idle();

        for (int i = 0; i < PlanRows; i++) begin
            s = '0;
            s.item.func     = plan[i].func;
            s.item.setpoint = plan[i].sp;
            s.fixed         = plan[i].fixed;
            s.want.mode     = plan[i].mode;
            s.want.status   = plan[i].st;
            stim_q.push_back(s);
        end
        run_stimulus();
        drain();

        for (int p = 0; p < Phases; p++) begin
            load_cfg(phase_cfg[p]);
            while (stim_q.size() < PhaseItems) begin
                if ($urandom_range(0, 4) == 0)
                    push_item(mdfr_pkg::t_func'($urandom_range(0, 3)), rand_sp());
                else
                    plan_drive_run();
            end
            run_stimulus();
            drain();
        end

        if (fail_cnt == 0)
            $display("tb_motor_drive_frequency_ramp OK");
        else
            $display("tb_motor_drive_frequency_ramp NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mdfr_pkg.sv
sv/mdfr_cfg.sv
sv/mdfr_ctrl.sv
sv/mdfr_scale.sv
sv/motor_drive_frequency_ramp.sv
tb/tb_motor_drive_frequency_ramp.sv
